// File: src/bm25_pkg.sv
package bm25_pkg;

	localparam int MAX_DOCS_DEF  = 1024;
	localparam int FRAC_BITS_DEF = 16;

	localparam int DOC_W    = 10;
	localparam int TF_W     = 16;
	localparam int LEN_W    = 16;
	localparam int DF_W     = 11;
	localparam int SCORE_W  = 32;
	localparam int CFG_W    = 24;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 80;

	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_ACCUM = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_INVALID = 2'd1;
	localparam logic [1:0] STATUS_SAT     = 2'd2;

	localparam logic [1:0] CFG_DOC_COUNT   = 2'd0;
	localparam logic [1:0] CFG_TOTAL_WORDS = 2'd1;
	localparam logic [1:0] CFG_K1          = 2'd2;
	localparam logic [1:0] CFG_B           = 2'd3;

	localparam logic [23:0] LN2_Q24 = 24'd11629080;

	function automatic logic [23:0] ln_entry(input logic [4:0] i);
		logic [23:0] v;
		case (i)
			5'd0:  v = 24'd0;
			5'd1:  v = 24'd1017112;
			5'd2:  v = 24'd1976071;
			5'd3:  v = 24'd2883169;
			5'd4:  v = 24'd3743728;
			5'd5:  v = 24'd4562291;
			5'd6:  v = 24'd5342767;
			5'd7:  v = 24'd6088544;
			5'd8:  v = 24'd6802576;
			5'd9:  v = 24'd7487455;
			5'd10: v = 24'd8145469;
			5'd11: v = 24'd8778647;
			5'd12: v = 24'd9388795;
			5'd13: v = 24'd9977530;
			5'd14: v = 24'd10546303;
			5'd15: v = 24'd11096425;
			5'd16: v = 24'd11629080;
			default: v = 24'd0;
		endcase
		return v;
	endfunction

	// Natural log in Q24 of a 12-bit integer of at least one.
	function automatic logic [27:0] ln_q24(input logic [11:0] x);
		logic [3:0]  e;
		logic [35:0] sh;
		logic [23:0] frac;
		logic [4:0]  idx;
		logic [23:0] lo;
		logic [23:0] hi;
		logic [19:0] diff;
		logic [39:0] prod;
		e = 4'd0;
		for (int i = 1; i < 12; i++) begin
			if (x[i]) begin
				e = 4'(i);
			end
		end
		sh = {24'd0, x} << (5'd24 - {1'b0, e});
		frac = sh[23:0];
		idx = {1'b0, frac[23:20]};
		lo = ln_entry(idx);
		hi = ln_entry(idx + 5'd1);
		diff = 20'(hi - lo);
		prod = 40'(diff) * 40'(frac[19:0]);
		return 28'(28'(e) * 28'(LN2_Q24)) + 28'(lo) + 28'(prod[39:20]);
	endfunction

endpackage

// File: src/bm25_ram.sv
module bm25_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/bm25_score_accumulator_top.sv
// BM25 score accumulator. Each input beat is one operation: clear, accumulate a posting, or
// read a document's score, and each produces exactly one output beat. The bit-serial
// divider runs twice per posting: 43 steps for the length ratio and 27 for the
// term-frequency ratio. A clear walks the score table one entry per cycle. The block
// is ready for the next input beat as soon as the output beat is registered. A stalled
// output beat holds the next operation in its done state until it is taken.
// After reset the same sweep of the score table runs before the first input beat is accepted.
// Configuration writes must be made only while no beat is in flight.
module bm25_score_accumulator_top #(
	parameter int MAX_DOCS  = bm25_pkg::MAX_DOCS_DEF,
	parameter int FRAC_BITS = bm25_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// doc_id, term_freq, doc_length, doc_freq, zero pad
	input  logic [bm25_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// func
	input  logic [1:0]                       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// doc_out, score, term_score, zero pad
	output logic [bm25_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// status
	output logic [1:0]                       m_axis_tuser,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [bm25_pkg::CFG_W-1:0]       cfg_wdata
);

	import bm25_pkg::*;

	localparam int ADDR_W = $clog2(MAX_DOCS);
	localparam int EXT_W  = 17;

	typedef enum logic [3:0] {
		S_IDLE, S_FETCH, S_DECODE, S_LNN, S_LND, S_DIV, S_NORM, S_DEN,
		S_PROD, S_TERM, S_SUM, S_DONE, S_CLEAR
	} state_t;

	state_t state_q;
	logic init_q;
	logic [ADDR_W-1:0] cnt_q;

	logic [10:0] doc_count_q;
	logic [23:0] total_words_q;
	logic [9:0]  k1_q;
	logic [8:0]  b_q;

	logic [1:0]  func_q;
	logic [DOC_W-1:0] doc_q;
	logic [TF_W-1:0]  tf_q;
	logic [LEN_W-1:0] len_q;
	logic [DF_W-1:0]  df_q;

	logic [27:0] lnn_q;
	logic [27:0] lnd_q;
	logic        neg_q;
	logic [27:0] idf_q;
	logic [42:0] quo_q;
	logic [46:0] rem_q;
	logic [5:0]  div_cnt_q;
	logic        div_sel_q;
	logic [43:0] norm_q;
	logic [46:0] den_q;
	logic [54:0] prod_q;
	logic signed [31:0] score_q;
	logic signed [31:0] term_q;
	logic [1:0]  status_q;

	logic [DOC_W-1:0] out_doc_q;
	logic [31:0] out_score_q;
	logic [31:0] out_term_q;
	logic [1:0]  out_status_q;
	logic        out_valid_q;

	logic [EXT_W-1:0] doc_ext;
	logic             in_range;
	logic             acc_ok;
	logic [8:0]       b_eff;
	logic [47:0]      trial;
	logic [47:0]      divisor;
	logic             fits;
	logic [55:0]      mag;
	logic signed [32:0] sum;
	logic [11:0]      x_n;
	logic [11:0]      x_d;
	logic [52:0]      norm_sum;
	logic [53:0]      k1_norm;
	logic [26:0]      num;
	logic [26:0]      len_n;
	logic             out_free;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [31:0]       ram_wdata;
	logic [31:0]       ram_rdata;

	always_comb begin
		doc_ext  = EXT_W'(doc_q);
		in_range = doc_ext < EXT_W'(MAX_DOCS);
		acc_ok   = in_range && (tf_q != '0) && (total_words_q != '0) &&
			(doc_count_q != '0) && (df_q <= doc_count_q);
		b_eff    = (b_q > 9'd256) ? 9'd256 : b_q;
		x_n      = {doc_count_q - df_q, 1'b1};
		x_d      = {df_q, 1'b1};
		divisor  = div_sel_q ? {1'b0, den_q} : {24'd0, total_words_q};
		trial    = {rem_q, quo_q[42]};
		fits     = trial >= divisor;
		norm_sum = 53'({9'd256 - b_eff, 16'd0}) + 53'(52'(b_eff) * 52'(quo_q));
		k1_norm  = 54'(k1_q) * 54'(norm_q);
		num      = 27'(27'(tf_q) * 27'({1'b0, k1_q} + 11'd256));
		len_n    = 27'(len_q) * 27'(doc_count_q);
		mag      = (56'(prod_q) + (56'(1) << (47 - FRAC_BITS))) >> (48 - FRAC_BITS);
		sum      = 33'(score_q) + 33'(term_q);
		out_free = !out_valid_q || m_axis_tready;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = '0;
		if (state_q == S_CLEAR) begin
			ram_we = 1'b1;
		end else if (state_q == S_SUM) begin
			ram_we    = 1'b1;
			ram_waddr = doc_ext[ADDR_W-1:0];
			ram_wdata = (sum[32] != sum[31]) ? (sum[32] ? 32'h80000000 : 32'h7FFFFFFF)
				: sum[31:0];
		end
	end

	bm25_ram #(
		.WIDTH (SCORE_W),
		.DEPTH (MAX_DOCS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (doc_ext[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_term_q, out_score_q, out_doc_q};
	assign m_axis_tuser  = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			init_q        <= 1'b1;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
			div_cnt_q     <= '0;
			div_sel_q     <= 1'b0;
			doc_count_q   <= 11'd1;
			total_words_q <= 24'd0;
			k1_q          <= 10'd307;
			b_q           <= 9'd192;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DOC_COUNT:   doc_count_q   <= cfg_wdata[10:0];
					CFG_TOTAL_WORDS: total_words_q <= cfg_wdata;
					CFG_K1:          k1_q          <= cfg_wdata[9:0];
					CFG_B:           b_q           <= cfg_wdata[8:0];
					default: ;
				endcase
			end
			if (out_valid_q && m_axis_tready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						func_q  <= s_axis_tuser;
						doc_q   <= s_axis_tdata[9:0];
						tf_q    <= s_axis_tdata[25:10];
						len_q   <= s_axis_tdata[41:26];
						df_q    <= s_axis_tdata[52:42];
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_DECODE;
				end
				S_DECODE: begin
					score_q  <= in_range ? signed'(ram_rdata) : 32'sd0;
					term_q   <= 32'sd0;
					status_q <= STATUS_OK;
					case (func_q)
						FUNC_CLEAR: begin
							cnt_q   <= '0;
							state_q <= S_CLEAR;
						end
						FUNC_ACCUM: begin
							if (acc_ok) begin
								state_q <= S_LNN;
							end else begin
								status_q <= STATUS_INVALID;
								state_q  <= S_DONE;
							end
						end
						FUNC_READ: begin
							if (!in_range) begin
								status_q <= STATUS_INVALID;
							end
							state_q <= S_DONE;
						end
						default: begin
							status_q <= STATUS_INVALID;
							state_q  <= S_DONE;
						end
					endcase
				end
				S_LNN: begin
					lnn_q   <= ln_q24(x_n);
					state_q <= S_LND;
				end
				S_LND: begin
					lnd_q     <= ln_q24(x_d);
					quo_q     <= {len_n, 16'd0};
					rem_q     <= '0;
					div_cnt_q <= 6'd43;
					div_sel_q <= 1'b0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					rem_q     <= fits ? 47'(trial - divisor) : trial[46:0];
					quo_q     <= {quo_q[41:0], fits};
					div_cnt_q <= div_cnt_q - 6'd1;
					if (div_cnt_q == 6'd1) begin
						state_q <= div_sel_q ? S_PROD : S_NORM;
					end
				end
				S_NORM: begin
					norm_q  <= norm_sum[51:8];
					neg_q   <= lnn_q < lnd_q;
					idf_q   <= (lnn_q < lnd_q) ? lnd_q - lnn_q : lnn_q - lnd_q;
					state_q <= S_DEN;
				end
				S_DEN: begin
					den_q     <= 47'({tf_q, 16'd0}) + k1_norm[53:8];
					rem_q     <= 47'({num, 5'd0});
					quo_q     <= '0;
					div_cnt_q <= 6'd27;
					div_sel_q <= 1'b1;
					state_q   <= S_DIV;
				end
				S_PROD: begin
					prod_q  <= 55'(idf_q) * 55'(quo_q[26:0]);
					state_q <= S_TERM;
				end
				S_TERM: begin
					if (neg_q) begin
						term_q <= (mag > 56'h80000000) ? 32'sh80000000 : signed'(32'(-mag));
					end else begin
						term_q <= (mag > 56'h7FFFFFFF) ? 32'sh7FFFFFFF : signed'(mag[31:0]);
					end
					state_q <= S_SUM;
				end
				S_SUM: begin
					score_q <= signed'(ram_wdata);
					if (sum[32] != sum[31]) begin
						status_q <= STATUS_SAT;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_doc_q    <= doc_q;
						out_score_q  <= score_q;
						out_term_q   <= term_q;
						out_status_q <= status_q;
						state_q      <= S_IDLE;
					end
				end
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ADDR_W'(MAX_DOCS - 1)) begin
						if (init_q) begin
							init_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							score_q <= 32'sd0;
							state_q <= S_DONE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_init_no_output: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !m_axis_tvalid)
		else $error("output beat during the reset sweep");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLEAR || state_q == S_SUM))
		else $error("table written outside clear or update");

	a_accept_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> state_q == S_FETCH)
		else $error("accepted beat did not start a fetch");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> div_cnt_q != 6'd0)
		else $error("divider running with zero step count");

endmodule
